// ===== rtl/core/htw_pkg.sv =====
// Shared types and constants for the hierarchical timer wheel.
// No dependencies; imported by every module of the block.
`default_nettype none
package htw_pkg;
  localparam int unsigned IdW   = 32;
  localparam int unsigned TimeW = 64;
  localparam int unsigned ActW  = 2;
  localparam int unsigned StW   = 2;
  localparam int unsigned LvlW  = 3;
  localparam int unsigned BktW  = 8;

  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_LATE = 2'd1,
    ST_FAR  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // Placement result: level 0 is root, k+1 is upper level k.
  typedef struct packed {
    logic            far;
    logic [LvlW-1:0] lvl;
    logic [BktW-1:0] bkt;
  } place_t;
endpackage
`default_nettype wire

// ===== rtl/core/htw_place.sv =====
// Bucket placement unit: maps a deadline against the current tick to a
// level and bucket. Depends on htw_pkg.
`default_nettype none
module htw_place #(
  parameter int unsigned ROOT_BITS    = 8,
  parameter int unsigned LEVEL_BITS   = 6,
  parameter int unsigned UPPER_LEVELS = 4
) (
  input  logic [htw_pkg::TimeW-1:0] end_i,
  input  logic [htw_pkg::TimeW-1:0] now_i,
  output htw_pkg::place_t           place_o
);
  import htw_pkg::*;
  logic [TimeW-1:0] e_hi, c_hi;
  logic             found;
  logic [TimeW-1:0] es;
  always_comb begin
    e_hi = end_i >> ROOT_BITS;
    c_hi = now_i >> ROOT_BITS;
    place_o.far = 1'b0;
    place_o.lvl = '0;
    place_o.bkt = BktW'(end_i & TimeW'((1 << ROOT_BITS) - 1));
    found = (e_hi == c_hi);
    es = '0;
    for (int k = 0; k < UPPER_LEVELS; k++) begin
      if (!found && ((e_hi >> (LEVEL_BITS*(k+1))) == (c_hi >> (LEVEL_BITS*(k+1))))) begin
        found = 1'b1;
        es = e_hi >> (LEVEL_BITS*k);
        place_o.lvl = LvlW'(k + 1);
        place_o.bkt = BktW'(es & TimeW'((1 << LEVEL_BITS) - 1));
      end
    end
    if (!found) place_o.far = 1'b1;
  end
endmodule
`default_nettype wire

// ===== rtl/core/hierarchical_timer_wheel.sv =====
// Top level of the hierarchical timer wheel: handshake, sequencer and pool.
// Depends on htw_pkg and htw_place.
//
// A pool of POOL_ENTRIES timers sits in a register array; one sequencer
// walks it one entry per cycle through a single placement unit, pausing in
// the expiry scan while the output is stalled. Insert and remove run one
// lookup sweep. A tick runs an expiry scan sweep, preceded by a cascade
// sweep when the root wraps and a cascade target exists. Each input gives one
// transfer, or one transfer per expired timer on a tick (one when none
// expired), the final one with tlast set. Input is not taken while an item
// is in work; the next input can be taken in the cycle after the final
// result transfer.
`default_nettype none
module hierarchical_timer_wheel #(
  parameter int unsigned POOL_ENTRIES = 32,
  parameter int unsigned ROOT_BITS    = 8,
  parameter int unsigned LEVEL_BITS   = 6,
  parameter int unsigned UPPER_LEVELS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: [1:0] action, [33:2] timer_id, [97:34] end_time, zero fill to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: [1:0] status, [2] expired_valid, [34:3] expired_id,
  //        [98:35] now_time, zero fill to 104
  output logic [103:0] m_axis_tdata,
  output logic         m_axis_tlast
);
  import htw_pkg::*;
  localparam int unsigned PW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_WRITE = 6'b000100,
    S_CASC  = 6'b001000,
    S_SCAN  = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [POOL_ENTRIES-1:0] used_q;
  logic [IdW-1:0]   ident_q [POOL_ENTRIES];
  logic [TimeW-1:0] dead_q  [POOL_ENTRIES];
  logic [LvlW-1:0]  lvl_q   [POOL_ENTRIES];
  logic [BktW-1:0]  bkt_q   [POOL_ENTRIES];

  logic [TimeW-1:0] now_q;
  logic [ActW-1:0]  act_q;
  logic [IdW-1:0]   id_q;
  logic [TimeW-1:0] end_q;
  logic [CW-1:0]    idx_q;
  logic             hit_q, free_q;
  logic [PW-1:0]    hit_idx_q, free_idx_q;
  logic             casc_ok_q;
  logic [LvlW-1:0]  casc_lvl_q;
  logic [BktW-1:0]  casc_bkt_q;
  logic             emitted_q;
  logic [IdW-1:0]   pend_id_q;
  logic             ovalid_q, olast_q, oexp_q;
  logic [StW-1:0]   ost_q;
  logic [IdW-1:0]   oid_q;

  logic [PW-1:0]    pi;
  logic             in_xfer, out_xfer, out_free;
  logic [TimeW-1:0] p_end, p_now;
  place_t           pl;
  logic [TimeW-1:0] now_inc;

  assign pi = idx_q[PW-1:0];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign now_inc = now_q + TimeW'(1);

  // One shared placement unit: insert deadline or cascading entry deadline.
  assign p_end = (state_q == S_CASC) ? dead_q[pi] : end_q;
  assign p_now = now_q;
  htw_place #(.ROOT_BITS(ROOT_BITS), .LEVEL_BITS(LEVEL_BITS),
              .UPPER_LEVELS(UPPER_LEVELS)) u_place (
    .end_i(p_end), .now_i(p_now), .place_o(pl));

  // Cascade target, derived from the tick being taken (now_inc; now_q not yet bumped).
  logic             c_ok;
  logic [LvlW-1:0]  c_lvl;
  logic [BktW-1:0]  c_bkt;
  logic [TimeW-1:0] c_c, c_l;
  logic             c_fnd;
  always_comb begin
    c_c = now_inc >> ROOT_BITS;
    c_l = now_q >> ROOT_BITS;
    c_ok = 1'b0; c_lvl = '0; c_bkt = '0; c_fnd = 1'b0;
    for (int k = 0; k < UPPER_LEVELS; k++) begin
      if (!c_fnd && ((c_l >> (LEVEL_BITS*(k+1))) == (c_c >> (LEVEL_BITS*(k+1))))) begin
        c_fnd = 1'b1;
        c_ok  = 1'b1;
        c_lvl = LvlW'(k + 1);
        c_bkt = BktW'((c_c >> (LEVEL_BITS*k)) & TimeW'((1 << LEVEL_BITS) - 1));
      end
    end
  end

  logic root_wrap;
  assign root_wrap = ((now_inc & TimeW'((1 << ROOT_BITS) - 1)) == '0);
  logic sweep_end;
  assign sweep_end = (idx_q == CW'(POOL_ENTRIES - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_xfer) begin
        if (action_e'(s_axis_tdata[1:0]) == ACT_TICK) state_d = S_CASC;
        else state_d = S_FIND;
      end
      S_FIND:  if (sweep_end) state_d = S_WRITE;
      S_WRITE: if (out_free) state_d = S_IDLE;
      S_CASC:  if (!casc_ok_q || sweep_end) state_d = S_SCAN;
      S_SCAN:  if (sweep_end && out_free) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic scan_hit;
  assign scan_hit = used_q[pi] && (lvl_q[pi] == '0) &&
                    (bkt_q[pi] == BktW'(now_q & TimeW'((1 << ROOT_BITS) - 1)));

  // Load a new result into the output register this cycle.
  logic oset;
  assign oset = out_free && ((state_q == S_WRITE) || (state_q == S_OUT) ||
                             ((state_q == S_SCAN) && scan_hit && emitted_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      now_q <= '0;
      idx_q <= '0;
      ovalid_q <= 1'b0;
      hit_q <= 1'b0; free_q <= 1'b0; casc_ok_q <= 1'b0; emitted_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (oset) ovalid_q <= 1'b1;
      else if (out_xfer) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_xfer) begin
          act_q <= s_axis_tdata[1:0];
          id_q  <= s_axis_tdata[33:2];
          end_q <= s_axis_tdata[97:34];
          idx_q <= '0;
          hit_q <= 1'b0; free_q <= 1'b0; emitted_q <= 1'b0;
          if (action_e'(s_axis_tdata[1:0]) == ACT_TICK) begin
            now_q <= now_inc;
            casc_ok_q  <= root_wrap && c_ok;
            casc_lvl_q <= c_lvl;
            casc_bkt_q <= c_bkt;
          end
        end
        S_FIND: begin
          // Hold the first live id match and the first free entry.
          if (!hit_q && used_q[pi] && ident_q[pi] == id_q) begin
            hit_q <= 1'b1; hit_idx_q <= pi;
          end
          if (!free_q && !used_q[pi]) begin
            free_q <= 1'b1; free_idx_q <= pi;
          end
          idx_q <= sweep_end ? '0 : idx_q + CW'(1);
        end
        S_WRITE: if (out_free) begin
          olast_q <= 1'b1; oexp_q <= 1'b0; oid_q <= '0;
          ost_q <= ST_OK;
          if (action_e'(act_q) == ACT_REMOVE) begin
            if (hit_q) used_q[hit_idx_q] <= 1'b0;
          end else if (action_e'(act_q) == ACT_INSERT) begin
            if (end_q <= now_q) ost_q <= ST_LATE;
            else if (pl.far) ost_q <= ST_FAR;
            else if (!hit_q && !free_q) ost_q <= ST_FULL;
            else begin
              used_q[hit_q ? hit_idx_q : free_idx_q] <= 1'b1;
              ident_q[hit_q ? hit_idx_q : free_idx_q] <= id_q;
              dead_q[hit_q ? hit_idx_q : free_idx_q] <= end_q;
              lvl_q[hit_q ? hit_idx_q : free_idx_q] <= pl.lvl;
              bkt_q[hit_q ? hit_idx_q : free_idx_q] <= pl.bkt;
            end
          end
        end
        S_CASC: begin
          if (casc_ok_q) begin
            if (used_q[pi] && lvl_q[pi] == casc_lvl_q && bkt_q[pi] == casc_bkt_q) begin
              if (dead_q[pi] < now_q || pl.far) used_q[pi] <= 1'b0;
              else begin
                lvl_q[pi] <= pl.lvl;
                bkt_q[pi] <= pl.bkt;
              end
            end
            idx_q <= sweep_end ? '0 : idx_q + CW'(1);
          end
        end
        S_SCAN: if (out_free) begin
          // Emit each hit when the next one is found (the final one from S_OUT), so tlast can be set on the final one.
          if (scan_hit) begin
            used_q[pi] <= 1'b0;
            if (emitted_q) begin
              olast_q <= 1'b0; oexp_q <= 1'b1; ost_q <= ST_OK;
              oid_q <= pend_id_q;
            end
            pend_id_q <= ident_q[pi];
            emitted_q <= 1'b1;
          end
          idx_q <= sweep_end ? '0 : idx_q + CW'(1);
        end
        S_OUT: if (out_free) begin
          olast_q <= 1'b1; ost_q <= ST_OK;
          oexp_q <= emitted_q;
          oid_q <= emitted_q ? pend_id_q : '0;
        end
        default: ;
      endcase
    end
  end

  // The pending id is overwritten only as the prior one is loaded into oid_q; send_id is oid_q.
  logic [IdW-1:0] send_id;
  assign send_id = oid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {5'd0, now_q, send_id, oexp_q, ost_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ovalid_q)
    else $error("input taken with a pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q != S_IDLE)
    else $error("sequencer did not start on a transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
endmodule
`default_nettype wire
